// ===== hdl/lsd_radix_sort_base10_unit_macros.svh =====
// Assertion macros shared by the decimal radix sort RTL
`ifndef LSD_RADIX_SORT_BASE10_UNIT_MACROS_SVH
`define LSD_RADIX_SORT_BASE10_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define LSD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define LSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/lsd_pkg.sv =====
// Types and constants of the decimal radix sort unit
`timescale 1ns / 1ps
`default_nettype none
package lsd_pkg;

	localparam int VAL_W         = 31;
	localparam int WORD_W        = 2 * VAL_W;
	localparam int RADIX         = 10;
	localparam int DIGIT_W       = 4;
	localparam int QUOT_W        = 28;
	localparam int RECIP_W       = 32;
	localparam int PROD_W        = VAL_W + RECIP_W;
	localparam int DIV10_SHIFT   = 35;
	localparam logic [RECIP_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
	localparam int MAX_ITEMS_DEF = 64;

	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] q;
		logic [VAL_W-1:0] tag;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               valid;
		logic [VAL_W-1:0]   quot;
		logic [DIGIT_W-1:0] rem;
		logic [VAL_W-1:0]   tag;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CHECK,
		ST_HIST,
		ST_HIST_DRAIN,
		ST_PREFIX,
		ST_SCAT,
		ST_SCAT_DRAIN,
		ST_MAXDIV,
		ST_MAXWAIT,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMIT_OUT
	} sort_state_t;

endpackage
`default_nettype wire

// ===== hdl/lsd_if.sv =====
// Valid/ready channel interfaces for input values and sorted results
`timescale 1ns / 1ps
`default_nettype none
interface lsd_in_if;
	import lsd_pkg::*;
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] value;
	logic             last;
	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

interface lsd_out_if;
	import lsd_pkg::*;
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] sorted_value;
	logic             final_res;
	logic             overflow;
	modport source (output valid, output sorted_value, output final_res, output overflow,
		input ready);
	modport sink (input valid, input sorted_value, input final_res, input overflow,
		output ready);
endinterface
`default_nettype wire

// ===== hdl/lsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module lsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hdl/lsd_div10.sv =====
// Two-stage divide-by-ten unit: quotient by reciprocal multiply, then remainder
`timescale 1ns / 1ps
`default_nettype none
module lsd_div10 (
	input  logic              clk,
	input  logic              arst_n,
	input  lsd_pkg::div_req_t req,
	output lsd_pkg::div_rsp_t rsp
);
	import lsd_pkg::*;

	logic [PROD_W-1:0]  prod;
	logic               valid_s1;
	logic [VAL_W-1:0]   q_s1;
	logic [VAL_W-1:0]   tag_s1;
	logic [QUOT_W-1:0]  quot_s1;
	logic [VAL_W-1:0]   tens;
	logic [VAL_W-1:0]   rem_full;
	logic               valid_s2;
	logic [VAL_W-1:0]   quot_s2;
	logic [DIGIT_W-1:0] rem_s2;
	logic [VAL_W-1:0]   tag_s2;

	// floor(q / 10) == (q * 0xCCCCCCCD) >> 35 for every 32-bit q
	assign prod = {{(PROD_W-VAL_W){1'b0}}, req.q} * {{(PROD_W-RECIP_W){1'b0}}, DIV10_RECIP};

	assign tens     = {quot_s1, 3'b000} + {2'b00, quot_s1, 1'b0};
	assign rem_full = q_s1 - tens;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		q_s1    <= req.q;
		tag_s1  <= req.tag;
		quot_s1 <= prod[DIV10_SHIFT +: QUOT_W];
		quot_s2 <= {{(VAL_W-QUOT_W){1'b0}}, quot_s1};
		rem_s2  <= rem_full[DIGIT_W-1:0];
		tag_s2  <= tag_s1;
	end

	assign rsp.busy  = valid_s1;
	assign rsp.valid = valid_s2;
	assign rsp.quot  = quot_s2;
	assign rsp.rem   = rem_s2;
	assign rsp.tag   = tag_s2;
endmodule
`default_nettype wire

// ===== hdl/lsd_radix_sort_base10_unit.sv =====
// Top level of the decimal LSD radix sort unit: sequencer, digit counters and buffers
//
// Values are loaded one word per cycle into a ping-pong buffer pair of MAX_ITEMS
// entries while the largest value is tracked; words past MAX_ITEMS are dropped and
// flag overflow on every result of the run. The word marked last starts the sort:
// each decimal pass is a histogram sweep and a scatter sweep through the single buffer
// read port with nine prefix-sum steps between them, both sweeps fed through the shared
// two-stage divide-by-ten unit, and one pass runs per decimal digit of the largest
// value, none when all values are zero. Sorted values then leave one word at a time,
// the next being read only once the sink has taken the current one. No input word is
// taken from the last word of a run until the final sorted word has been taken.
`timescale 1ns / 1ps
`default_nettype none
`include "lsd_radix_sort_base10_unit_macros.svh"
module lsd_radix_sort_base10_unit #(
	parameter int MAX_ITEMS = lsd_pkg::MAX_ITEMS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	lsd_in_if.sink    din,
	lsd_out_if.source dout
);
	import lsd_pkg::*;

	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	sort_state_t state_q, state_d;

	logic [CNT_W-1:0]   cnt_q;
	logic [VAL_W-1:0]   max_q;
	logic               drop_q;
	logic               sel_q;
	logic [IDX_W-1:0]   idx_q;
	logic [DIGIT_W-1:0] pre_q;
	logic               rd_vld_q;
	logic [CNT_W-1:0]   digit_cnt_q [RADIX];
	logic [VAL_W-1:0]   out_val_q;
	logic               out_fin_q;
	logic               out_ovf_q;

	logic               rd_issue;
	logic               pipe_busy;
	logic               room;
	logic               load_we;
	logic               scat_we;
	logic [IDX_W-1:0]   last_idx;
	logic [IDX_W-1:0]   scat_pos;
	logic [WORD_W-1:0]  scat_word;
	logic [WORD_W-1:0]  rd_word;
	logic [WORD_W-1:0]  rdata_a;
	logic [WORD_W-1:0]  rdata_b;
	logic               we_a;
	logic [IDX_W-1:0]   waddr_a;
	logic [WORD_W-1:0]  wdata_a;
	logic               we_b;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign last_idx  = IDX_W'(cnt_q - 1'b1);
	assign room      = (cnt_q < CNT_W'(MAX_ITEMS));
	assign load_we   = (state_q == ST_LOAD) && din.valid && room;
	assign scat_we   = div_rsp.valid && ((state_q == ST_SCAT) || (state_q == ST_SCAT_DRAIN));
	assign scat_pos  = IDX_W'(digit_cnt_q[div_rsp.rem] - 1'b1);
	assign scat_word = {div_rsp.tag, div_rsp.quot};
	assign rd_word   = sel_q ? rdata_b : rdata_a;
	assign pipe_busy = rd_vld_q || div_rsp.busy || div_rsp.valid;

	// Buffer A takes loads and the scatter of passes that read B, B the scatter of passes that read A
	assign we_a    = load_we || (scat_we && sel_q);
	assign waddr_a = (state_q == ST_LOAD) ? cnt_q[IDX_W-1:0] : scat_pos;
	assign wdata_a = (state_q == ST_LOAD) ? {din.value, din.value} : scat_word;
	assign we_b    = scat_we && !sel_q;

	lsd_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_ITEMS)
	) u_buf_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr_a),
		.wdata (wdata_a),
		.raddr (idx_q),
		.rdata (rdata_a)
	);

	lsd_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_ITEMS)
	) u_buf_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (scat_pos),
		.wdata (scat_word),
		.raddr (idx_q),
		.rdata (rdata_b)
	);

	lsd_div10 u_div10 (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign din.ready         = (state_q == ST_LOAD);
	assign dout.valid        = (state_q == ST_EMIT_OUT);
	assign dout.sorted_value = out_val_q;
	assign dout.final_res    = out_fin_q;
	assign dout.overflow     = out_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		rd_issue      = 1'b0;
		div_req.valid = rd_vld_q;
		div_req.q     = rd_word[VAL_W-1:0];
		div_req.tag   = rd_word[WORD_W-1:VAL_W];
		case (state_q)
			ST_LOAD: begin
				if (din.valid && din.last) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = (max_q != '0) ? ST_HIST : ST_EMIT_RD;
			end
			ST_HIST: begin
				rd_issue = 1'b1;
				if (idx_q == last_idx) begin
					state_d = ST_HIST_DRAIN;
				end
			end
			ST_HIST_DRAIN: begin
				if (!pipe_busy) begin
					state_d = ST_PREFIX;
				end
			end
			ST_PREFIX: begin
				if (pre_q == DIGIT_W'(RADIX - 1)) begin
					state_d = ST_SCAT;
				end
			end
			ST_SCAT: begin
				rd_issue = 1'b1;
				if (idx_q == '0) begin
					state_d = ST_SCAT_DRAIN;
				end
			end
			ST_SCAT_DRAIN: begin
				if (!pipe_busy) begin
					state_d = ST_MAXDIV;
				end
			end
			ST_MAXDIV: begin
				div_req.valid = 1'b1;
				div_req.q     = max_q;
				div_req.tag   = max_q;
				state_d       = ST_MAXWAIT;
			end
			ST_MAXWAIT: begin
				if (div_rsp.valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				state_d = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				if (dout.ready) begin
					state_d = out_fin_q ? ST_LOAD : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			max_q    <= '0;
			drop_q   <= 1'b0;
			sel_q    <= 1'b0;
			idx_q    <= '0;
			pre_q    <= '0;
			rd_vld_q <= 1'b0;
			for (int k = 0; k < RADIX; k++) begin
				digit_cnt_q[k] <= '0;
			end
		end else begin
			rd_vld_q <= rd_issue;
			case (state_q)
				ST_LOAD: begin
					if (din.valid) begin
						if (room) begin
							cnt_q <= cnt_q + 1'b1;
							if (din.value > max_q) begin
								max_q <= din.value;
							end
						end else begin
							drop_q <= 1'b1;
						end
					end
				end
				ST_CHECK: begin
					idx_q <= '0;
					pre_q <= DIGIT_W'(1);
					for (int k = 0; k < RADIX; k++) begin
						digit_cnt_q[k] <= '0;
					end
				end
				ST_HIST, ST_HIST_DRAIN: begin
					if (state_q == ST_HIST) begin
						idx_q <= idx_q + 1'b1;
					end
					if (div_rsp.valid) begin
						digit_cnt_q[div_rsp.rem] <= digit_cnt_q[div_rsp.rem] + 1'b1;
					end
				end
				ST_PREFIX: begin
					digit_cnt_q[pre_q] <= digit_cnt_q[pre_q] + digit_cnt_q[pre_q - 1'b1];
					pre_q              <= pre_q + 1'b1;
					idx_q              <= last_idx;
				end
				ST_SCAT, ST_SCAT_DRAIN: begin
					if (state_q == ST_SCAT) begin
						idx_q <= idx_q - 1'b1;
					end
					// Slot for this word is one below its digit's running end
					if (div_rsp.valid) begin
						digit_cnt_q[div_rsp.rem] <= digit_cnt_q[div_rsp.rem] - 1'b1;
					end
				end
				ST_MAXWAIT: begin
					if (div_rsp.valid) begin
						max_q <= div_rsp.quot;
						sel_q <= ~sel_q;
					end
				end
				ST_EMIT_OUT: begin
					if (dout.ready) begin
						if (out_fin_q) begin
							cnt_q  <= '0;
							max_q  <= '0;
							drop_q <= 1'b0;
							sel_q  <= 1'b0;
							idx_q  <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_LD) begin
			out_val_q <= rd_word[WORD_W-1:VAL_W];
			out_fin_q <= (idx_q == last_idx);
			out_ovf_q <= drop_q;
		end
	end

	`LSD_ASSERT_IMPL(a_no_load_while_emit, clk, arst_n, dout.valid, !din.ready,
		"input taken while a result is pending")
	`LSD_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(MAX_ITEMS),
		"item count beyond buffer depth")
	`LSD_ASSERT_IMPL(a_scat_slot, clk, arst_n, scat_we, digit_cnt_q[div_rsp.rem] != '0,
		"scatter into an empty digit bucket")
	`LSD_ASSERT_IMPL(a_rem_digit, clk, arst_n, div_rsp.valid, div_rsp.rem < DIGIT_W'(RADIX),
		"remainder is not a decimal digit")
	`LSD_ASSERT_NEXT(a_run_clears, clk, arst_n, dout.valid && dout.ready && dout.final_res,
		(cnt_q == '0) && !drop_q && !sel_q, "run state not cleared after final word")
endmodule
`default_nettype wire
